// ===== rtl/core/rpfl_pkg.sv =====
// rpfl_pkg: shared operation and status codes and stream field layout of the row pool
`timescale 1ns / 1ps
`default_nettype none

package rpfl_pkg;

  localparam int WORD_W     = 32;
  localparam int IDX_PORT_W = 10;
  localparam int FLD_PORT_W = 2;
  localparam int CNT_PORT_W = 11;
  localparam int OP_W       = 3;
  localparam int ST_W       = 2;

  // request: operation, entry_index, field_select, write_value, one pad bit
  localparam int IN_TDATA_W  = 48;
  // result: read_value, slot, entry_count, status, one pad bit
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_FREE   = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_DROP   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpfl_row_mem.sv =====
// rpfl_row_mem: one read and one write port, one row per address, registered read data
`timescale 1ns / 1ps
`default_nettype none

module rpfl_row_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int ROW_W  = 128
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [ROW_W-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    // data holds while no read is issued
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/row_pool_with_free_list.sv =====
// row_pool_with_free_list: pool of rows with an intrusive LIFO free list, top level
//
// Usage: requests enter on the in_ stream (operation, entry_index, field_select,
// write_value) and each request gives exactly one result on the out_ stream
// (read_value, slot, entry_count, status), in request order.
// Timing: a request is taken only when the sequencer is idle. The accept edge
// issues a read of the addressed row and enters the execute state, where the
// row is modified and written back and the result register loaded, which then
// drives out_tvalid. The next request is taken only once the previous one has
// left the execute state, so requests are handled one at a time.
// Stall: the result register is a one-deep output stage. While it still holds
// an untaken result a new request is accepted and its row read; the
// write-back and the result then wait until out_tready takes the old one.
// Reset: entry count zero, free list empty, no result pending. There is no
// clearing pass: a high-water mark of entries ever in use makes rows never
// reached read as zero, and such a row is written in full when first reached.
`timescale 1ns / 1ps
`default_nettype none

module row_pool_with_free_list
  import rpfl_pkg::*;
#(
  parameter int ENTRIES = 1024,
  parameter int FIELDS  = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] operation, [12:3] entry_index, [14:13] field_select, [46:15] write_value
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [31:0] read_value, [41:32] slot, [52:42] entry_count, [54:53] status
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int FLD_W = (FIELDS > 1) ? $clog2(FIELDS) : 1;
  localparam int ROW_W = FIELDS * WORD_W;
  localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);
  localparam logic [31:0] FIELDS_W  = 32'(FIELDS);

  typedef logic [FIELDS-1:0][WORD_W-1:0] row_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state_r, state_nxt;
  op_t                     op_r;
  logic [IDX_PORT_W-1:0]   idx_r;
  logic [FLD_PORT_W-1:0]   fld_r;
  logic [WORD_W-1:0]       val_r;
  logic [IDX_W-1:0]        addr_r;
  logic                    fresh_r;
  logic [CNT_W-1:0]        used_r, used_nxt;
  logic [CNT_W-1:0]        hw_r, hw_nxt;
  logic                    head_valid_r, head_valid_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  logic                    in_accept;
  logic [31:0]             rd_addr_w;
  logic [IDX_W-1:0]        rd_addr;
  logic [ROW_W-1:0]        mem_rdata;
  logic                    mem_wr_en;
  row_t                    row, wr_row;
  logic                    done;

  logic [31:0]             used_w, idx_w, fld_w, link, cnt_w, slot_w;
  logic [FLD_W-1:0]        fld_i;
  logic                    fld_ok, idx_ok, full;
  logic [WORD_W-1:0]       rd_val;
  status_t                 status;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // row to read for the incoming request
  always_comb begin
    case (op_t'(in_tdata[2:0]))
      OP_APPEND: rd_addr_w = 32'(used_r);
      OP_ALLOC:  rd_addr_w = head_valid_r ? 32'(head_r) : 32'(used_r);
      default:   rd_addr_w = 32'(in_tdata[12:3]);
    endcase
  end
  assign rd_addr = rd_addr_w[IDX_W-1:0];

  rpfl_row_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W),
    .ROW_W  (ROW_W)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (mem_rdata),
    .wr_en   (mem_wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_row)
  );

  // rows at or above the high-water mark were never written and read as zero
  assign row    = fresh_r ? row_t'(mem_rdata) : '0;
  assign used_w = 32'(used_r);
  assign idx_w  = 32'(idx_r);
  assign fld_w  = 32'(fld_r);
  assign fld_i  = fld_w[FLD_W-1:0];
  assign link   = row[0];
  assign fld_ok = fld_w < FIELDS_W;
  assign idx_ok = idx_w < used_w;
  assign full   = used_w >= ENTRIES_W;
  assign done   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    wr_row         = row;
    mem_wr_en      = 1'b0;
    used_nxt       = used_r;
    hw_nxt         = hw_r;
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    rd_val         = '0;
    slot_w         = '0;
    status         = ST_OK;
    case (op_r)
      OP_APPEND: begin
        if (!fld_ok) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          wr_row[fld_i] = val_r;
          mem_wr_en     = 1'b1;
          slot_w        = used_w;
          used_nxt      = used_r + CNT_W'(1);
          if (used_r == hw_r) begin
            hw_nxt = used_r + CNT_W'(1);
          end
        end
      end
      OP_ALLOC: begin
        if (head_valid_r) begin
          slot_w = 32'(head_r);
          if (link < ENTRIES_W) begin
            head_nxt = link[IDX_W-1:0];
          end else begin
            head_valid_nxt = 1'b0;
            head_nxt       = '0;
          end
        end else if (full) begin
          status = ST_FULL;
        end else begin
          // write back so a row reached for the first time becomes zero in memory
          mem_wr_en = 1'b1;
          slot_w    = used_w;
          used_nxt  = used_r + CNT_W'(1);
          if (used_r == hw_r) begin
            hw_nxt = used_r + CNT_W'(1);
          end
        end
      end
      OP_FREE: begin
        if (!idx_ok) begin
          status = ST_RANGE;
        end else begin
          wr_row[0]      = head_valid_r ? 32'(head_r) : '1;
          mem_wr_en      = 1'b1;
          head_nxt       = idx_w[IDX_W-1:0];
          head_valid_nxt = 1'b1;
        end
      end
      OP_READ: begin
        if (!idx_ok || !fld_ok) begin
          status = ST_RANGE;
        end else begin
          rd_val = row[fld_i];
        end
      end
      OP_WRITE: begin
        if (!idx_ok || !fld_ok) begin
          status = ST_RANGE;
        end else begin
          wr_row[fld_i] = val_r;
          mem_wr_en     = 1'b1;
        end
      end
      OP_DROP: begin
        if (used_r == '0) begin
          status = ST_EMPTY;
        end else begin
          used_nxt = used_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        used_nxt       = '0;
        head_valid_nxt = 1'b0;
        head_nxt       = '0;
      end
      default: begin
      end
    endcase
    if (!done) begin
      mem_wr_en = 1'b0;
    end
  end

  assign cnt_w = 32'(used_nxt);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, status, cnt_w[CNT_PORT_W-1:0],
                           slot_w[IDX_PORT_W-1:0], rd_val};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      hw_r         <= '0;
      head_valid_r <= 1'b0;
      head_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (done) begin
        used_r       <= used_nxt;
        hw_r         <= hw_nxt;
        head_valid_r <= head_valid_nxt;
        head_r       <= head_nxt;
      end
    end
    if (in_accept) begin
      op_r    <= op_t'(in_tdata[2:0]);
      idx_r   <= in_tdata[12:3];
      fld_r   <= in_tdata[14:13];
      val_r   <= in_tdata[46:15];
      addr_r  <= rd_addr;
      fresh_r <= rd_addr_w < 32'(hw_r);
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_used_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= hw_r)
    else $error("entry count above high-water mark");

  a_mark_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hw_r >= $past(hw_r))
    else $error("high-water mark decreased");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result loaded outside execute cycle");

endmodule

`default_nettype wire
